### src/mpc_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Widths, register indexes, reset values and the types shared between the
// front part, the step queue and the point emitter.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int COORD_BITS   = 12;
  localparam int RADIUS_BITS  = 10;
  localparam int PIX_BITS     = COORD_BITS + 1;
  localparam int REG_BITS     = 11;
  localparam int COLOR_BITS   = 32;
  localparam int XY_BITS      = RADIUS_BITS + 1;
  localparam int DEC_BITS     = RADIUS_BITS + 4;
  localparam int SUM_BITS     = ((COORD_BITS > XY_BITS) ? COORD_BITS : XY_BITS) + 1;
  localparam int CMP_BITS     = ((SUM_BITS > REG_BITS) ? SUM_BITS : REG_BITS) + 1;
  localparam int CFG_IDX_BITS = 2;
  localparam int PT_BITS      = 3;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_BITS   = 1;

  localparam logic [PT_BITS-1:0] LAST_PT = PT_BITS'(7);

  localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic [REG_BITS-1:0] WIDTH_RESET  = REG_BITS'(720);
  localparam logic [REG_BITS-1:0] HEIGHT_RESET = REG_BITS'(576);

  typedef enum logic [0:0] {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [XY_BITS-1:0]    x;
    logic signed [XY_BITS-1:0]    y;
    logic [COLOR_BITS-1:0]        color;
    logic                         fin;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### src/mpc_if.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer channels
// Input item channel, point output channel and register write channel.
// ----------------------------------------------------------------------------
interface mpc_in_if;
  import mpc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [RADIUS_BITS-1:0]       radius;
  logic [COLOR_BITS-1:0]        color;

  modport source (output valid, kind, center_x, center_y, radius, color, input ready);
  modport sink (input valid, kind, center_x, center_y, radius, color, output ready);
endinterface

interface mpc_out_if;
  import mpc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [PIX_BITS-1:0] pixel_x;
  logic signed [PIX_BITS-1:0] pixel_y;
  logic [COLOR_BITS-1:0]      pixel_color;
  logic                       visible;
  logic                       last;
  logic                       done_res;

  modport source (output valid, pixel_x, pixel_y, pixel_color, visible, last, done_res,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, visible, last, done_res,
                output ready);
endinterface

interface mpc_cfg_if;
  import mpc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] reg_index;
  logic [REG_BITS-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

### src/mpc_front.sv
// ----------------------------------------------------------------------------
// Midpoint circle front part
// Accepts items, keeps the circle walker, queues a job per active step item.
// ----------------------------------------------------------------------------
module mpc_front (
  input  logic            clk,
  input  logic            rst,
  mpc_in_if.sink          item_in,
  input  mpc_pkg::q_stat_t q_stat,
  output logic            push,
  output mpc_pkg::job_t   job
);
  import mpc_pkg::*;

  localparam logic signed [DEC_BITS-1:0] DEC_THREE = DEC_BITS'(3);
  localparam logic signed [DEC_BITS-1:0] DEC_SIX   = DEC_BITS'(6);
  localparam logic signed [DEC_BITS-1:0] DEC_TEN   = DEC_BITS'(10);
  localparam logic signed [XY_BITS-1:0]  XY_ONE    = XY_BITS'(1);

  logic                         active;
  logic signed [COORD_BITS-1:0] center_col;
  logic signed [COORD_BITS-1:0] center_row;
  logic signed [XY_BITS-1:0]    step_x;
  logic signed [XY_BITS-1:0]    step_y;
  logic signed [DEC_BITS-1:0]   decision;
  logic [COLOR_BITS-1:0]        held_color;

  logic                         accept;
  logic                         is_step;
  logic signed [DEC_BITS-1:0]   x_ext;
  logic signed [DEC_BITS-1:0]   y_ext;
  logic signed [DEC_BITS-1:0]   decision_next;
  logic signed [XY_BITS-1:0]    step_x_next;
  logic signed [XY_BITS-1:0]    step_y_next;
  logic signed [XY_BITS-1:0]    radius_s;
  logic signed [DEC_BITS-1:0]   radius_ext;
  logic                         fin;

  assign item_in.ready = !q_stat.full;
  assign accept        = item_in.valid && item_in.ready;
  assign is_step       = (item_in.kind == KIND_STEP);

  assign x_ext      = DEC_BITS'(step_x);
  assign y_ext      = DEC_BITS'(step_y);
  assign radius_s   = $signed({1'b0, item_in.radius});
  assign radius_ext = DEC_BITS'(radius_s);

  always_comb begin
    if (decision[DEC_BITS-1]) begin
      decision_next = decision + (x_ext <<< 2) + DEC_SIX;
      step_y_next   = step_y;
    end else begin
      decision_next = decision + ((x_ext - y_ext) <<< 2) + DEC_TEN;
      step_y_next   = step_y - XY_ONE;
    end
    step_x_next = step_x + XY_ONE;
    fin         = (step_x_next > step_y_next);
  end

  assign push      = accept && is_step && active;
  assign job.cx    = center_col;
  assign job.cy    = center_row;
  assign job.x     = step_x;
  assign job.y     = step_y;
  assign job.color = held_color;
  assign job.fin   = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept) begin
      if (!is_step) begin
        active <= 1'b1;
      end else if (active && fin) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!is_step) begin
        center_col <= item_in.center_x;
        center_row <= item_in.center_y;
        held_color <= item_in.color;
        step_x     <= '0;
        step_y     <= radius_s;
        decision   <= DEC_THREE - (radius_ext <<< 1);
      end else if (active) begin
        step_x   <= step_x_next;
        step_y   <= step_y_next;
        decision <= decision_next;
      end
    end
  end

endmodule

### src/mpc_queue.sv
// ----------------------------------------------------------------------------
// Midpoint circle step queue
// Short first-in first-out queue of step jobs between front and back parts.
// ----------------------------------------------------------------------------
module mpc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mpc_pkg::job_t    wr_job,
  input  logic             pop,
  output mpc_pkg::job_t    rd_job,
  output mpc_pkg::q_stat_t stat
);
  import mpc_pkg::*;

  job_t                  entries [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_PTR_BITS:0]   count;

  assign stat.full  = (count == (Q_PTR_BITS + 1)'(Q_DEPTH));
  assign stat.empty = (count == '0);
  assign rd_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

### src/mpc_back.sv
// ----------------------------------------------------------------------------
// Midpoint circle point emitter
// Expands one queued step into its eight symmetric points, one per cycle
// when the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module mpc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  mpc_pkg::job_t                head,
  input  mpc_pkg::q_stat_t             q_stat,
  output logic                         pop,
  input  logic [mpc_pkg::REG_BITS-1:0] surface_width,
  input  logic [mpc_pkg::REG_BITS-1:0] surface_height,
  mpc_out_if.source                    pix_out
);
  import mpc_pkg::*;

  logic                       busy;
  logic [PT_BITS-1:0]         pt;
  job_t                       cur;

  logic                       out_valid;
  logic signed [PIX_BITS-1:0] out_x;
  logic signed [PIX_BITS-1:0] out_y;
  logic [COLOR_BITS-1:0]      out_color;
  logic                       out_visible;
  logic                       out_last;
  logic                       out_done;

  logic                       advance;
  logic                       load;
  logic signed [XY_BITS-1:0]  col_off;
  logic signed [XY_BITS-1:0]  row_off;
  logic signed [SUM_BITS-1:0] col_sum;
  logic signed [SUM_BITS-1:0] row_sum;
  logic                       col_ok;
  logic                       row_ok;

  assign advance = busy && (!out_valid || pix_out.ready);
  assign load    = !q_stat.empty && (!busy || (advance && (pt == LAST_PT)));
  assign pop     = load;

  always_comb begin
    col_off = pt[2] ? cur.y : cur.x;
    row_off = pt[2] ? cur.x : cur.y;
    col_sum = pt[0] ? (SUM_BITS'(cur.cx) - SUM_BITS'(col_off))
                    : (SUM_BITS'(cur.cx) + SUM_BITS'(col_off));
    row_sum = pt[1] ? (SUM_BITS'(cur.cy) - SUM_BITS'(row_off))
                    : (SUM_BITS'(cur.cy) + SUM_BITS'(row_off));
    col_ok  = !col_sum[SUM_BITS-1] &&
              ($unsigned(CMP_BITS'(col_sum)) < CMP_BITS'(surface_width));
    row_ok  = !row_sum[SUM_BITS-1] &&
              ($unsigned(CMP_BITS'(row_sum)) < CMP_BITS'(surface_height));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pt        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && pix_out.ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        pt        <= pt + 1'b1;
      end
      if (load) begin
        busy <= 1'b1;
        pt   <= '0;
      end else if (advance && (pt == LAST_PT)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head;
    end
    if (advance) begin
      out_x       <= PIX_BITS'(col_sum);
      out_y       <= PIX_BITS'(row_sum);
      out_color   <= cur.color;
      out_visible <= col_ok && row_ok;
      out_last    <= (pt == LAST_PT);
      out_done    <= cur.fin;
    end
  end

  assign pix_out.valid       = out_valid;
  assign pix_out.pixel_x     = out_x;
  assign pix_out.pixel_y     = out_y;
  assign pix_out.pixel_color = out_color;
  assign pix_out.visible     = out_visible;
  assign pix_out.last        = out_last;
  assign pix_out.done_res    = out_done;

endmodule

### src/midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer
// A start item loads center, radius and color and gives no points. Each
// step item on a running circle gives eight points, one per cycle while
// the output is not stalled; the point emitter owns the single output
// register. A two-entry step queue lets the front part take up to two
// more steps while points are still going out.
// Points carry a visible flag from the surface width and height registers.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer (
  input  logic      clk,
  input  logic      rst,
  mpc_in_if.sink    item_in,
  mpc_out_if.source pix_out,
  mpc_cfg_if.sink   cfg
);
  import mpc_pkg::*;

  logic [REG_BITS-1:0] surface_width;
  logic [REG_BITS-1:0] surface_height;

  logic    q_push;
  logic    q_pop;
  job_t    q_wr_job;
  job_t    q_rd_job;
  q_stat_t q_stat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= WIDTH_RESET;
      surface_height <= HEIGHT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.reg_index == REG_SURFACE_WIDTH) begin
        surface_width <= cfg.wdata;
      end else if (cfg.reg_index == REG_SURFACE_HEIGHT) begin
        surface_height <= cfg.wdata;
      end
    end
  end

  mpc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item_in (item_in),
    .q_stat  (q_stat),
    .push    (q_push),
    .job     (q_wr_job)
  );

  mpc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (q_wr_job),
    .pop    (q_pop),
    .rd_job (q_rd_job),
    .stat   (q_stat)
  );

  mpc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (q_rd_job),
    .q_stat         (q_stat),
    .pop            (q_pop),
    .surface_width  (surface_width),
    .surface_height (surface_height),
    .pix_out        (pix_out)
  );

`ifndef SYNTHESIS
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (!q_stat.full || q_pop))
    else $error("step queue overflow");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("step queue underflow");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !item_in.ready)
    else $error("input ready while step queue full");
`endif

endmodule
